[sv/box_qp_random_coordinate_descent_defines.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the box QP coordinate descent block
// Clocked on clk_i, disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef BOX_QP_RANDOM_COORDINATE_DESCENT_DEFINES_SVH
`define BOX_QP_RANDOM_COORDINATE_DESCENT_DEFINES_SVH

// same-cycle implication
`define BQPRCD_ASSERT_IMPL(name, pre, post, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error(msg);

// next-cycle implication
`define BQPRCD_ASSERT_NEXT(name, pre, post, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

[sv/bqprcd_pkg.sv]
// ----------------------------------------------------------------------------
// bqprcd_pkg
// Shared types, codes and saturating arithmetic for the coordinate descent QP.
// ----------------------------------------------------------------------------
`default_nettype none

package bqprcd_pkg;

  localparam int DEF_MAX_DIM       = 256;
  localparam int DEF_MAX_NONZEROS  = 4096;
  localparam int DEF_FRACTION_BITS = 16;

  localparam int MAX_REPORTS = 64;
  localparam logic [31:0] LFSR_TAPS = 32'h8020_0003;

  // stream payload layout
  localparam int S_TDATA_W = 48;
  localparam int S_TUSER_W = 3;
  localparam int M_TDATA_W = 72;
  localparam int EPOCH_LSB = 64;
  localparam int FAULT_BIT = 70;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;

  typedef enum logic [2:0] {
    OP_LOAD_ENTRY = 3'd0,
    OP_LOAD_RHS   = 3'd1,
    OP_SOLVE      = 3'd2,
    OP_READ       = 3'd3,
    OP_CLEAR      = 3'd4
  } op_e;

  typedef enum logic {
    KIND_RESIDUAL = 1'b0,
    KIND_SOLUTION = 1'b1
  } kind_e;

  typedef enum logic [2:0] {
    CFG_DIMENSION  = 3'd0,
    CFG_MAX_EPOCHS = 3'd1,
    CFG_PRECISION  = 3'd2,
    CFG_LOWER      = 3'd3,
    CFG_UPPER      = 3'd4,
    CFG_INITIAL    = 3'd5,
    CFG_SEED       = 3'd6
  } cfg_e;

  localparam logic signed [63:0] S64_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [63:0] S64_MIN = 64'sh8000_0000_0000_0000;

  function automatic logic signed [63:0] sat_add64(logic signed [63:0] a,
                                                   logic signed [63:0] b);
    logic signed [64:0] s;
    s = {a[63], a} + {b[63], b};
    if (s[64] != s[63]) return s[64] ? S64_MIN : S64_MAX;
    return s[63:0];
  endfunction

  // subtracting the most negative value keeps a negative minuend as it is
  function automatic logic signed [63:0] sat_sub64(logic signed [63:0] a,
                                                   logic signed [63:0] b);
    if (b == S64_MIN) return a[63] ? a : S64_MAX;
    return sat_add64(a, -b);
  endfunction

  function automatic logic signed [31:0] sat32(logic signed [63:0] x);
    if (x > 64'sh0000_0000_7FFF_FFFF) return 32'sh7FFF_FFFF;
    if (x < -64'sh0000_0000_8000_0000) return 32'sh8000_0000;
    return x[31:0];
  endfunction

endpackage

`default_nettype wire

[sv/bqprcd_mul.sv]
// ----------------------------------------------------------------------------
// bqprcd_mul
// Shared signed 33x33 multiplier with a registered product.
// ----------------------------------------------------------------------------
`default_nettype none

module bqprcd_mul import bqprcd_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic signed [32:0] a_i,
  input  wire logic signed [32:0] b_i,
  output logic signed [63:0]      p_o
);

  logic signed [65:0] prod;

  assign prod = a_i * b_i;

  // all products used here fit in 64 bits
  always_ff @(posedge clk_i) begin
    p_o <= prod[63:0];
  end

endmodule

`default_nettype wire

[sv/bqprcd_div.sv]
// ----------------------------------------------------------------------------
// bqprcd_div
// Restoring divider, one quotient bit per cycle, 32-bit saturated result.
// ----------------------------------------------------------------------------
`default_nettype none

module bqprcd_div import bqprcd_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start_i,
  input  wire logic signed [63:0] num_i,
  input  wire logic signed [31:0] den_i,
  output logic                    done_o,
  output logic signed [31:0]      quot_o
);

  localparam int STEPS = 64;

  logic [6:0]  cnt_q;
  logic        done_q;
  logic [63:0] acc_q;
  logic [31:0] rem_q;
  logic [31:0] md_q;
  logic        neg_q;

  logic [32:0] sh;
  logic [32:0] diff;
  logic        ge;

  assign sh   = {rem_q, acc_q[63]};
  assign diff = sh - {1'b0, md_q};
  assign ge   = (sh >= {1'b0, md_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else if (start_i) begin
      cnt_q  <= 7'(STEPS);
      done_q <= 1'b0;
    end else if (cnt_q != '0) begin
      cnt_q  <= cnt_q - 7'd1;
      done_q <= (cnt_q == 7'd1);
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      acc_q <= num_i[63] ? (64'd0 - num_i) : num_i;
      rem_q <= '0;
      md_q  <= den_i[31] ? (32'd0 - den_i) : den_i;
      neg_q <= num_i[63] ^ den_i[31];
    end else if (cnt_q != '0) begin
      acc_q <= {acc_q[62:0], ge};
      rem_q <= ge ? diff[31:0] : sh[31:0];
    end
  end

  always_comb begin
    if (!neg_q) begin
      quot_o = (acc_q > 64'h0000_0000_7FFF_FFFF) ? 32'sh7FFF_FFFF : acc_q[31:0];
    end else begin
      quot_o = (acc_q >= 64'h0000_0000_8000_0000) ? 32'sh8000_0000
                                                  : (32'd0 - acc_q[31:0]);
    end
  end

  assign done_o = done_q;

endmodule

`default_nettype wire

[sv/box_qp_random_coordinate_descent.sv]
// Loads: a matrix load that opens columns writes each new column start in S_CSW.
//   A read passes S_RD0 and S_RD1 before its result is registered.
// Solve: a gradient clear sweep, column walks over all entries and a residual pass
//   come before the first report; each epoch runs d updates, each walking its column
//   twice around a divider wait, then a gradient rebuild if unboxed, and a residual pass.
// One request at a time. Reset clears all control state; no memory clearing pass.
// ----------------------------------------------------------------------------
// box_qp_random_coordinate_descent
// Randomized coordinate descent solver for a box-constrained sparse QP,
// Q16.16 data, 64-bit saturating gradient, squared KKT residual per epoch.
// ----------------------------------------------------------------------------
`default_nettype none

module box_qp_random_coordinate_descent import bqprcd_pkg::*; #(
  parameter int MAX_DIM       = DEF_MAX_DIM,
  parameter int MAX_NONZEROS  = DEF_MAX_NONZEROS,
  parameter int FRACTION_BITS = DEF_FRACTION_BITS
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  // request stream
  input  wire logic                  s_axis_tvalid,
  output logic                       s_axis_tready,
  input  wire logic [S_TDATA_W-1:0]  s_axis_tdata,  // row[7:0], column[15:8], value[47:16]
  input  wire logic [S_TUSER_W-1:0]  s_axis_tuser,  // op[2:0]
  // result stream
  output logic                       m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  output logic [M_TDATA_W-1:0]       m_axis_tdata,  // result_value[63:0], epoch[69:64],
                                                    // fault[70], zero[71]
  output logic                       m_axis_tuser,  // kind[0]
  output logic                       m_axis_tlast,  // last
  // configuration writes
  input  wire logic                  cfg_valid_i,
  output logic                       cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam int DIM_W = $clog2(MAX_DIM);
  localparam int IDX_W = DIM_W + 1;
  localparam int NZ_W  = $clog2(MAX_NONZEROS);
  localparam int CNT_W = $clog2(MAX_NONZEROS + 1);
  localparam logic signed [63:0] HALF = 64'sd1 <<< (FRACTION_BITS - 1);

  // sequencer states
  localparam logic [4:0] S_IDLE  = 5'd0;
  localparam logic [4:0] S_CSW   = 5'd1;   // column start fill after a load
  localparam logic [4:0] S_RD0   = 5'd2;
  localparam logic [4:0] S_RD1   = 5'd3;
  localparam logic [4:0] S_INIT  = 5'd4;
  localparam logic [4:0] S_ZERO  = 5'd5;   // gradient clear sweep, first pass also sets sol
  localparam logic [4:0] S_BCOL  = 5'd6;
  localparam logic [4:0] S_BNEXT = 5'd7;
  localparam logic [4:0] S_CS0   = 5'd8;   // column walk: fetch bounds
  localparam logic [4:0] S_CS1   = 5'd9;
  localparam logic [4:0] S_CS2   = 5'd10;
  localparam logic [4:0] S_E0    = 5'd11;  // column walk: one entry
  localparam logic [4:0] S_E1    = 5'd12;
  localparam logic [4:0] S_E2    = 5'd13;
  localparam logic [4:0] S_R0    = 5'd14;  // residual
  localparam logic [4:0] S_R1    = 5'd15;
  localparam logic [4:0] S_R2    = 5'd16;
  localparam logic [4:0] S_R3    = 5'd17;
  localparam logic [4:0] S_REP   = 5'd18;
  localparam logic [4:0] S_U0    = 5'd19;  // coordinate update
  localparam logic [4:0] S_U1    = 5'd20;
  localparam logic [4:0] S_U2    = 5'd21;
  localparam logic [4:0] S_U3    = 5'd22;
  localparam logic [4:0] S_U4    = 5'd23;
  localparam logic [4:0] S_U5    = 5'd24;
  localparam logic [4:0] S_U6    = 5'd25;
  localparam logic [4:0] S_UNEXT = 5'd26;
  localparam logic [4:0] S_A0    = 5'd27;  // gradient rebuild, unboxed
  localparam logic [4:0] S_A1    = 5'd28;
  localparam logic [4:0] S_ANEXT = 5'd29;

  // request fields
  logic [7:0]         in_row;
  logic [7:0]         in_col;
  logic signed [31:0] in_val;
  logic               in_acc;
  assign in_row = s_axis_tdata[7:0];
  assign in_col = s_axis_tdata[15:8];
  assign in_val = s_axis_tdata[47:16];

  // configuration
  logic [8:0]         dim_q;
  logic [6:0]         maxep_q;
  logic [62:0]        prec_q;
  logic signed [31:0] lb_q, ub_q, iv_q;
  logic [31:0]        seed_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dim_q   <= 9'd2;
      maxep_q <= 7'd64;
      prec_q  <= '0;
      lb_q    <= '0;
      ub_q    <= 32'sd65536;
      iv_q    <= '0;
      seed_q  <= 32'd1;
    end else if (cfg_valid_i) begin
      case (cfg_e'(cfg_index_i))
        CFG_DIMENSION:  dim_q   <= cfg_data_i[8:0];
        CFG_MAX_EPOCHS: maxep_q <= cfg_data_i[6:0];
        CFG_PRECISION:  prec_q  <= cfg_data_i[62:0];
        CFG_LOWER:      lb_q    <= cfg_data_i[31:0];
        CFG_UPPER:      ub_q    <= cfg_data_i[31:0];
        CFG_INITIAL:    iv_q    <= cfg_data_i[31:0];
        CFG_SEED:       seed_q  <= cfg_data_i[31:0];
        default: ;
      endcase
    end
  end

  // control and datapath registers
  logic [4:0]         state_q, state_d, ret_q, ret_d;
  logic [IDX_W-1:0]   i_q, i_d, k_q, k_d, d_q, d_d;
  logic [6:0]         n_q, n_d, me_q, me_d;
  logic               boxed_q, boxed_d, fault_q, fault_d, init_q, init_d;
  logic               sub_q, sub_d, use_q, use_d;
  logic signed [31:0] start_q, start_d, x_q, x_d, den_q, den_d;
  logic [31:0]        lfsr_q, lfsr_d;
  logic [DIM_W-1:0]   col_q, col_d, idx_q, idx_d, erow_q, erow_d;
  logic [DIM_W-1:0]   last_col_q, last_col_d, csw_k_q, csw_k_d;
  logic [CNT_W-1:0]   j_q, j_d, jend_q, jend_d, cnt_q, cnt_d, csw_val_q, csw_val_d;
  logic [7:0]         row_q, row_d;
  logic signed [63:0] df_q, df_d, sum_q, sum_d;
  logic [MAX_DIM-1:0] diag_vld_q, diag_vld_d;

  // result register
  logic               ov_q, ov_d, olast_q, olast_d, ofault_q, ofault_d;
  logic               okind_q, okind_d;
  logic signed [63:0] oval_q, oval_d;
  logic [5:0]         oep_q, oep_d;
  logic               out_free;

  assign out_free = !ov_q || m_axis_tready;

  // memories
  logic signed [31:0] mval_mem [MAX_NONZEROS];
  logic [7:0]         mrow_mem [MAX_NONZEROS];
  logic [CNT_W-1:0]   cs_mem   [MAX_DIM];
  logic signed [31:0] diag_mem [MAX_DIM];
  logic signed [31:0] rhs_mem  [MAX_DIM];
  logic signed [31:0] sol_mem  [MAX_DIM];
  logic signed [63:0] grad_mem [MAX_DIM];

  logic signed [31:0] mval_rd_q, diag_rd_q, rhs_rd_q, sol_rd_q;
  logic [7:0]         mrow_rd_q;
  logic [CNT_W-1:0]   cs_rd_q;
  logic signed [63:0] grad_rd_q;

  logic               mat_we, cs_we, diag_we, rhs_we, sol_we, grad_we;
  logic [DIM_W-1:0]   diag_wa, rhs_wa, sol_wa, grad_wa, ptr, cs_ra, grad_ra;
  logic signed [31:0] sol_wd;
  logic signed [63:0] grad_wd;

  always_ff @(posedge clk_i) begin
    if (mat_we) begin
      mval_mem[cnt_q[NZ_W-1:0]] <= in_val;
      mrow_mem[cnt_q[NZ_W-1:0]] <= in_row;
    end
    mval_rd_q <= mval_mem[j_q[NZ_W-1:0]];
    mrow_rd_q <= mrow_mem[j_q[NZ_W-1:0]];
  end

  always_ff @(posedge clk_i) begin
    if (cs_we) cs_mem[csw_k_q] <= csw_val_q;
    cs_rd_q <= cs_mem[cs_ra];
  end

  always_ff @(posedge clk_i) begin
    if (diag_we) diag_mem[diag_wa] <= in_val;
    diag_rd_q <= diag_mem[idx_q];
  end

  always_ff @(posedge clk_i) begin
    if (rhs_we) rhs_mem[rhs_wa] <= in_val;
    rhs_rd_q <= rhs_mem[ptr];
  end

  always_ff @(posedge clk_i) begin
    if (sol_we) sol_mem[sol_wa] <= sol_wd;
    sol_rd_q <= sol_mem[ptr];
  end

  always_ff @(posedge clk_i) begin
    if (grad_we) grad_mem[grad_wa] <= grad_wd;
    grad_rd_q <= grad_mem[grad_ra];
  end

  // shared multiplier and divider
  logic signed [32:0] mul_a, mul_b;
  logic signed [63:0] mul_p;
  logic               div_start, div_done;
  logic signed [63:0] div_num;
  logic signed [31:0] div_quot;

  bqprcd_mul u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (mul_p)
  );

  bqprcd_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (den_q),
    .done_o  (div_done),
    .quot_o  (div_quot)
  );

  // read address selection
  logic upd_st, rd_st;
  assign upd_st = state_q inside {S_U2, S_U3, S_U4, S_U5, S_U6};
  assign rd_st  = state_q inside {S_RD0, S_RD1};
  assign ptr    = upd_st ? idx_q : (rd_st ? DIM_W'(row_q) : i_q[DIM_W-1:0]);
  assign grad_ra = (state_q == S_E1) ? DIM_W'(mrow_rd_q) : ptr;

  logic [IDX_W-1:0] col_p1;
  assign col_p1 = {1'b0, col_q} + IDX_W'(1);
  assign cs_ra  = (state_q == S_CS0) ? col_q : col_p1[DIM_W-1:0];

  // helpers
  logic signed [63:0] rhs_scaled, r_round, r_shift, mul_q_ext;
  logic signed [31:0] q32, x_clamp, d_start;
  logic [31:0]        lfsr_step;
  logic               diag_zero, done_rep;
  logic [IDX_W-1:0]   d_clamp;

  assign rhs_scaled = {{32{rhs_rd_q[31]}}, rhs_rd_q} <<< FRACTION_BITS;
  assign r_round    = sat_add64(df_q, HALF);
  assign r_shift    = r_round >>> FRACTION_BITS;  // floor
  assign q32        = sat32(r_shift);
  assign mul_q_ext  = 64'(q32);
  assign lfsr_step  = (lfsr_q >> 1) ^ (lfsr_q[0] ? LFSR_TAPS : 32'd0);
  assign diag_zero  = !diag_vld_q[idx_q] || (diag_rd_q == 32'sd0);
  assign done_rep   = ({1'b0, sum_q} <= {2'b00, prec_q}) || ((n_q + 7'd1) >= me_q);
  assign div_num    = sat_sub64(rhs_scaled, grad_rd_q);
  assign div_start  = (state_q == S_U5);

  always_comb begin
    if (dim_q < 9'd2) d_clamp = IDX_W'(2);
    else if (32'(dim_q) > MAX_DIM) d_clamp = IDX_W'(MAX_DIM);
    else d_clamp = IDX_W'(dim_q);
  end

  always_comb begin
    d_start = 32'sd0;
    if (lb_q < ub_q) d_start = (iv_q < lb_q || iv_q > ub_q) ? lb_q : iv_q;
  end

  always_comb begin
    x_clamp = div_quot;
    if (boxed_q) begin
      if (div_quot > ub_q) x_clamp = ub_q;
      else if (div_quot < lb_q) x_clamp = lb_q;
    end
  end

  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state_q == S_IDLE);

  // sequencer
  always_comb begin
    state_d = state_q;  ret_d = ret_q;
    i_d = i_q;  k_d = k_q;  d_d = d_q;  n_d = n_q;  me_d = me_q;
    boxed_d = boxed_q;  fault_d = fault_q;  init_d = init_q;
    sub_d = sub_q;  use_d = use_q;  start_d = start_q;  x_d = x_q;  den_d = den_q;
    lfsr_d = lfsr_q;  col_d = col_q;  idx_d = idx_q;  erow_d = erow_q;
    last_col_d = last_col_q;  csw_k_d = csw_k_q;  csw_val_d = csw_val_q;
    j_d = j_q;  jend_d = jend_q;  cnt_d = cnt_q;  row_d = row_q;
    df_d = df_q;  sum_d = sum_q;  diag_vld_d = diag_vld_q;
    ov_d = ov_q && !m_axis_tready;
    olast_d = olast_q;  ofault_d = ofault_q;  okind_d = okind_q;
    oval_d = oval_q;  oep_d = oep_q;
    mat_we = 1'b0;  cs_we = 1'b0;  diag_we = 1'b0;  rhs_we = 1'b0;
    sol_we = 1'b0;  grad_we = 1'b0;
    diag_wa = DIM_W'(in_col);  rhs_wa = DIM_W'(in_row);
    sol_wa = i_q[DIM_W-1:0];  sol_wd = start_q;
    grad_wa = i_q[DIM_W-1:0];  grad_wd = '0;
    mul_a = '0;  mul_b = '0;

    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          case (op_e'(s_axis_tuser))
            OP_LOAD_ENTRY: begin
              if (32'(in_row) < MAX_DIM && 32'(in_col) < MAX_DIM &&
                  32'(cnt_q) < MAX_NONZEROS &&
                  !(cnt_q != '0 && DIM_W'(in_col) < last_col_q)) begin
                mat_we = 1'b1;
                cnt_d  = cnt_q + CNT_W'(1);
                if (in_row == in_col) begin
                  diag_we = 1'b1;
                  diag_vld_d[DIM_W'(in_col)] = 1'b1;
                end
                // record the start of every newly opened column
                if (DIM_W'(in_col) > last_col_q) begin
                  csw_k_d   = last_col_q + DIM_W'(1);
                  csw_val_d = cnt_q;
                  col_d     = DIM_W'(in_col);
                  state_d   = S_CSW;
                end
                last_col_d = DIM_W'(in_col);
              end
            end
            OP_LOAD_RHS: rhs_we = (32'(in_row) < MAX_DIM);
            OP_SOLVE:    state_d = S_INIT;
            OP_READ: begin
              row_d   = in_row;
              state_d = S_RD0;
            end
            OP_CLEAR: begin
              cnt_d      = '0;
              last_col_d = '0;
              diag_vld_d = '0;
            end
            default: ;
          endcase
        end
      end

      S_CSW: begin
        cs_we = 1'b1;
        if (csw_k_q == col_q) state_d = S_IDLE;
        else csw_k_d = csw_k_q + DIM_W'(1);
      end

      S_RD0: state_d = S_RD1;

      S_RD1: begin
        if (out_free) begin
          ov_d     = 1'b1;
          okind_d  = KIND_SOLUTION;
          oval_d   = (32'(row_q) < MAX_DIM) ? 64'(sol_rd_q) : 64'sd0;
          oep_d    = '0;
          olast_d  = 1'b1;
          ofault_d = fault_q;
          state_d  = S_IDLE;
        end
      end

      S_INIT: begin
        d_d     = d_clamp;
        me_d    = (maxep_q == '0) ? 7'd1
                : ((32'(maxep_q) > MAX_REPORTS) ? 7'(MAX_REPORTS) : maxep_q);
        boxed_d = (lb_q < ub_q);
        start_d = d_start;
        lfsr_d  = (seed_q == '0) ? 32'd1 : seed_q;
        fault_d = 1'b0;
        n_d     = '0;
        i_d     = '0;
        init_d  = 1'b1;
        state_d = S_ZERO;
      end

      S_ZERO: begin
        grad_we = 1'b1;
        sol_we  = init_q && (i_q < d_q);
        if (32'(i_q) == MAX_DIM - 1) begin
          i_d     = '0;
          state_d = init_q ? S_BCOL : S_A0;
        end else begin
          i_d = i_q + IDX_W'(1);
        end
      end

      S_BCOL: begin
        col_d   = i_q[DIM_W-1:0];
        x_d     = start_q;
        sub_d   = 1'b0;
        ret_d   = S_BNEXT;
        state_d = S_CS0;
      end

      S_BNEXT: begin
        if (i_q + IDX_W'(1) < d_q) begin
          i_d     = i_q + IDX_W'(1);
          state_d = S_BCOL;
        end else begin
          i_d     = '0;
          sum_d   = '0;
          state_d = S_R0;
        end
      end

      S_A0: state_d = S_A1;

      S_A1: begin
        col_d   = i_q[DIM_W-1:0];
        x_d     = sol_rd_q;
        sub_d   = 1'b0;
        ret_d   = S_ANEXT;
        state_d = S_CS0;
      end

      S_ANEXT: begin
        if (i_q + IDX_W'(1) < d_q) begin
          i_d     = i_q + IDX_W'(1);
          state_d = S_A0;
        end else begin
          i_d     = '0;
          sum_d   = '0;
          state_d = S_R0;
        end
      end

      // column bounds: start(0) is zero, columns past the last loaded one
      // start at the current entry count
      S_CS0: state_d = S_CS1;

      S_CS1: begin
        if (col_q == '0) j_d = '0;
        else if (col_q <= last_col_q) j_d = cs_rd_q;
        else j_d = cnt_q;
        state_d = S_CS2;
      end

      S_CS2: begin
        jend_d = (col_p1 <= {1'b0, last_col_q}) ? cs_rd_q : cnt_q;
        if (j_q < jend_d) state_d = S_E0;
        else state_d = ret_q;
      end

      S_E0: state_d = S_E1;

      S_E1: begin
        mul_a   = 33'(mval_rd_q);
        mul_b   = sub_q ? -33'(x_q) : 33'(x_q);
        erow_d  = DIM_W'(mrow_rd_q);
        state_d = S_E2;
      end

      S_E2: begin
        grad_we = 1'b1;
        grad_wa = erow_q;
        grad_wd = sat_add64(grad_rd_q, mul_p);
        if (j_q + CNT_W'(1) < jend_q) begin
          j_d     = j_q + CNT_W'(1);
          state_d = S_E0;
        end else begin
          state_d = ret_q;
        end
      end

      S_R0: state_d = S_R1;

      S_R1: begin
        df_d    = sat_sub64(grad_rd_q, rhs_scaled);
        state_d = S_R2;
      end

      S_R2: begin
        mul_a = 33'(q32);
        mul_b = 33'(q32);
        use_d = 1'b1;
        if (boxed_q) begin
          if (sol_rd_q <= lb_q) use_d = mul_q_ext < 64'sd0;
          else if (sol_rd_q >= ub_q) use_d = mul_q_ext > 64'sd0;
        end
        state_d = S_R3;
      end

      S_R3: begin
        if (use_q) sum_d = sat_add64(sum_q, mul_p);
        if (i_q + IDX_W'(1) < d_q) begin
          i_d     = i_q + IDX_W'(1);
          state_d = S_R0;
        end else begin
          state_d = S_REP;
        end
      end

      S_REP: begin
        if (out_free) begin
          ov_d     = 1'b1;
          okind_d  = KIND_RESIDUAL;
          oval_d   = sum_q;
          oep_d    = n_q[5:0];
          olast_d  = done_rep;
          ofault_d = fault_q;
          n_d      = n_q + 7'd1;
          k_d      = '0;
          state_d  = done_rep ? S_IDLE : S_U0;
        end
      end

      S_U0: begin
        lfsr_d  = lfsr_step;
        mul_a   = {1'b0, lfsr_step};
        mul_b   = 33'(d_q);
        state_d = S_U1;
      end

      S_U1: begin
        idx_d   = mul_p[32 +: DIM_W];
        state_d = S_U2;
      end

      S_U2: state_d = S_U3;

      S_U3: begin
        den_d = diag_rd_q;
        if (diag_zero) begin
          fault_d = 1'b1;
          state_d = S_UNEXT;
        end else begin
          x_d     = sol_rd_q;
          col_d   = idx_q;
          sub_d   = 1'b1;
          ret_d   = S_U4;
          state_d = S_CS0;
        end
      end

      S_U4: state_d = S_U5;

      S_U5: state_d = S_U6;

      S_U6: begin
        if (div_done) begin
          sol_we  = 1'b1;
          sol_wa  = idx_q;
          sol_wd  = x_clamp;
          x_d     = x_clamp;
          col_d   = idx_q;
          sub_d   = 1'b0;
          ret_d   = S_UNEXT;
          state_d = S_CS0;
        end
      end

      S_UNEXT: begin
        if (k_q + IDX_W'(1) < d_q) begin
          k_d     = k_q + IDX_W'(1);
          state_d = S_U0;
        end else if (boxed_q) begin
          i_d     = '0;
          sum_d   = '0;
          state_d = S_R0;
        end else begin
          i_d     = '0;
          init_d  = 1'b0;
          state_d = S_ZERO;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      ret_q      <= S_IDLE;
      i_q        <= '0;
      k_q        <= '0;
      n_q        <= '0;
      d_q        <= IDX_W'(2);
      me_q       <= 7'd1;
      boxed_q    <= 1'b0;
      fault_q    <= 1'b0;
      init_q     <= 1'b0;
      lfsr_q     <= 32'd1;
      last_col_q <= '0;
      csw_k_q    <= '0;
      j_q        <= '0;
      jend_q     <= '0;
      cnt_q      <= '0;
      diag_vld_q <= '0;
      ov_q       <= 1'b0;
    end else begin
      state_q    <= state_d;
      ret_q      <= ret_d;
      i_q        <= i_d;
      k_q        <= k_d;
      n_q        <= n_d;
      d_q        <= d_d;
      me_q       <= me_d;
      boxed_q    <= boxed_d;
      fault_q    <= fault_d;
      init_q     <= init_d;
      lfsr_q     <= lfsr_d;
      last_col_q <= last_col_d;
      csw_k_q    <= csw_k_d;
      j_q        <= j_d;
      jend_q     <= jend_d;
      cnt_q      <= cnt_d;
      diag_vld_q <= diag_vld_d;
      ov_q       <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sub_q     <= sub_d;
    use_q     <= use_d;
    start_q   <= start_d;
    x_q       <= x_d;
    den_q     <= den_d;
    col_q     <= col_d;
    idx_q     <= idx_d;
    erow_q    <= erow_d;
    csw_val_q <= csw_val_d;
    row_q     <= row_d;
    df_q      <= df_d;
    sum_q     <= sum_d;
    olast_q   <= olast_d;
    ofault_q  <= ofault_d;
    okind_q   <= okind_d;
    oval_q    <= oval_d;
    oep_q     <= oep_d;
  end

  assign m_axis_tvalid = ov_q;
  assign m_axis_tdata  = {1'b0, ofault_q, oep_q, oval_q};
  assign m_axis_tuser  = okind_q;
  assign m_axis_tlast  = olast_q;

endmodule

`default_nettype wire

[sv/bqprcd_checker.sv]
// ----------------------------------------------------------------------------
// bqprcd_checker
// Port-level checks on the coordinate descent QP block.
// ----------------------------------------------------------------------------
`default_nettype none

`include "box_qp_random_coordinate_descent_defines.svh"

module bqprcd_checker import bqprcd_pkg::*; (
  input wire logic                  clk_i,
  input wire logic                  rst_ni,
  input wire logic                  s_axis_tvalid,
  input wire logic                  s_axis_tready,
  input wire logic [S_TDATA_W-1:0]  s_axis_tdata,
  input wire logic [S_TUSER_W-1:0]  s_axis_tuser,
  input wire logic                  m_axis_tvalid,
  input wire logic                  m_axis_tready,
  input wire logic [M_TDATA_W-1:0]  m_axis_tdata,
  input wire logic                  m_axis_tuser,
  input wire logic                  m_axis_tlast,
  input wire logic                  cfg_valid_i,
  input wire logic                  cfg_ready_o,
  input wire logic [CFG_IDX_W-1:0]  cfg_index_i,
  input wire logic [CFG_DATA_W-1:0] cfg_data_i
);

  logic [5:0] epoch;
  assign epoch = m_axis_tdata[EPOCH_LSB +: 6];

  `BQPRCD_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast), "result changed while stalled")

  `BQPRCD_ASSERT_IMPL(a_read_single, m_axis_tvalid && m_axis_tuser == KIND_SOLUTION, m_axis_tlast && epoch == 6'd0, "solution result not single")

  `BQPRCD_ASSERT_IMPL(a_res_nonneg, m_axis_tvalid && m_axis_tuser == KIND_RESIDUAL, !m_axis_tdata[63], "negative squared residual")

  `BQPRCD_ASSERT_NEXT(a_solve_busy, s_axis_tvalid && s_axis_tready && s_axis_tuser == OP_SOLVE, !s_axis_tready, "ready during solve")

endmodule

bind box_qp_random_coordinate_descent bqprcd_checker u_bqprcd_checker (.*);

`default_nettype wire

[tb/tb_box_qp_random_coordinate_descent_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Result checker for the box QP coordinate descent solver
// Follows every accepted request and register write, predicts the result
// stream and compares it field by field with what the block sends.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_box_qp_random_coordinate_descent_checker import bqprcd_pkg::*; (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  s_axis_tvalid,
  input  wire logic                  s_axis_tready,
  input  wire logic [S_TDATA_W-1:0]  s_axis_tdata,
  input  wire logic [S_TUSER_W-1:0]  s_axis_tuser,
  input  wire logic                  m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  input  wire logic [M_TDATA_W-1:0]  m_axis_tdata,
  input  wire logic                  m_axis_tuser,
  input  wire logic                  m_axis_tlast,
  input  wire logic                  cfg_valid_i,
  input  wire logic                  cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,
  output int                         errors_o,
  output int                         pending_o,
  output int                         checked_o
);

  localparam int DIM   = DEF_MAX_DIM;
  localparam int NNZ   = DEF_MAX_NONZEROS;
  localparam int FRAC  = DEF_FRACTION_BITS;
  localparam longint HALF_LSB = longint'(1) <<< (FRAC - 1);

  typedef struct {
    kind_e       kind;
    logic [63:0] value;
    logic [5:0]  epoch;
    logic        last;
    logic        fault;
  } outcome_t;

  outcome_t outcome_q[$];

  // solver state
  logic signed [31:0] mat_val[NNZ];
  logic [7:0]         mat_row[NNZ];
  int unsigned        col_start[DIM+1];
  int unsigned        n_entries, prev_col;
  logic signed [31:0] diag[DIM], rhs_v[DIM], sol[DIM];
  longint             grad[DIM];
  logic [31:0]        lfsr;
  logic               fault_flag;

  // registers
  int unsigned        r_dim, r_epochs;
  logic [63:0]        r_prec;
  logic signed [31:0] r_lo, r_hi, r_init;
  logic [31:0]        r_seed;

  function automatic longint add_sat(longint a, longint b);
    if (b > 0 && a > S64_MAX - b) return S64_MAX;
    if (b < 0 && a < S64_MIN - b) return S64_MIN;
    return a + b;
  endfunction

  function automatic longint sub_sat(longint a, longint b);
    if (b == S64_MIN) return (a >= 0) ? S64_MAX : a;
    return add_sat(a, -b);
  endfunction

  function automatic longint clip32(longint x);
    if (x > 64'sh7FFF_FFFF) return 64'sh7FFF_FFFF;
    if (x < -64'sh8000_0000) return -64'sh8000_0000;
    return x;
  endfunction

  // truncating divide, saturated to 32 bits
  function automatic logic signed [31:0] div_sat(longint num, logic signed [31:0] den);
    logic [63:0] mn, md, q;
    logic        neg;
    mn  = (num < 0) ? 64'(-num) : 64'(num);
    md  = (den < 0) ? 64'(-longint'(den)) : 64'(longint'(den));
    q   = mn / md;
    neg = (num < 0) != (den < 0);
    if (!neg) return (q > 64'h7FFF_FFFF) ? 32'sh7FFF_FFFF : q[31:0];
    if (q >= 64'h8000_0000) return 32'sh8000_0000;
    return -q[31:0];
  endfunction

  function automatic void column_into_gradient(int unsigned col, logic signed [31:0] x,
                                               bit negate);
    int unsigned stop;
    longint      p;
    stop = col_start[col+1];
    if (stop > n_entries) stop = n_entries;
    for (int unsigned j = col_start[col]; j < stop && j < NNZ; j++) begin
      p = longint'(mat_val[j]) * longint'(x);
      grad[mat_row[j]] = add_sat(grad[mat_row[j]], negate ? -p : p);
    end
  endfunction

  function automatic longint kkt_sq(int unsigned d, bit boxed);
    longint sum, df, q;
    bit     counts;
    sum = 0;
    for (int unsigned i = 0; i < d; i++) begin
      df = sub_sat(grad[i], longint'(rhs_v[i]) <<< FRAC);
      q  = clip32(add_sat(df, HALF_LSB) >>> FRAC);
      counts = 1'b1;
      if (boxed) begin
        if (sol[i] <= r_lo) counts = q < 0;
        else if (sol[i] >= r_hi) counts = q > 0;
      end
      if (counts) sum = add_sat(sum, q * q);
    end
    return sum;
  endfunction

  function automatic void predict_solve();
    int unsigned        d, me, n, idx;
    bit                 boxed, stop;
    logic signed [31:0] x0, x;
    logic [63:0]        prod;
    longint             res;
    d  = (r_dim < 2) ? 2 : (r_dim > DIM) ? DIM : r_dim;
    me = (r_epochs < 1) ? 1 : (r_epochs > MAX_REPORTS) ? MAX_REPORTS : r_epochs;
    boxed = r_lo < r_hi;
    x0 = 0;
    if (boxed) x0 = (r_init < r_lo || r_init > r_hi) ? r_lo : r_init;
    fault_flag = 1'b0;
    lfsr = (r_seed != 0) ? r_seed : 32'd1;
    foreach (grad[i]) grad[i] = 0;
    for (int unsigned i = 0; i < d; i++) sol[i] = x0;
    for (int unsigned i = 0; i < d; i++) column_into_gradient(i, x0, 1'b0);
    res = kkt_sq(d, boxed);
    n = 0;
    forever begin
      stop = (64'(res) <= r_prec) || (n + 1 >= me);
      outcome_q.push_back('{KIND_RESIDUAL, 64'(res), n[5:0], stop, fault_flag});
      n++;
      if (stop) break;
      for (int unsigned k = 0; k < d; k++) begin
        lfsr = (lfsr >> 1) ^ (lfsr[0] ? LFSR_TAPS : 32'd0);
        prod = {32'd0, lfsr} * 64'(d);
        idx  = prod[63:32];
        if (diag[idx] == 0) begin
          fault_flag = 1'b1;
          continue;
        end
        column_into_gradient(idx, sol[idx], 1'b1);
        x = div_sat(sub_sat(longint'(rhs_v[idx]) <<< FRAC, grad[idx]), diag[idx]);
        if (boxed) begin
          if (x > r_hi) x = r_hi;
          else if (x < r_lo) x = r_lo;
        end
        sol[idx] = x;
        column_into_gradient(idx, x, 1'b0);
      end
      // unboxed solve rebuilds the gradient exactly after each epoch
      if (!boxed) begin
        foreach (grad[i]) grad[i] = 0;
        for (int unsigned i = 0; i < d; i++) column_into_gradient(i, sol[i], 1'b0);
      end
      res = kkt_sq(d, boxed);
    end
  endfunction

  function automatic void predict_request(logic [2:0] op, logic [7:0] row,
                                          logic [7:0] col, logic signed [31:0] val);
    case (op)
      OP_LOAD_ENTRY: begin
        if (n_entries < NNZ && !(n_entries != 0 && col < prev_col)) begin
          mat_val[n_entries] = val;
          mat_row[n_entries] = row;
          n_entries++;
          prev_col = col;
          for (int unsigned k = col + 1; k <= DIM; k++) col_start[k] = n_entries;
          if (row == col) diag[col] = val;
        end
      end
      OP_LOAD_RHS: rhs_v[row] = val;
      OP_SOLVE:    predict_solve();
      OP_READ:     outcome_q.push_back('{KIND_SOLUTION, 64'(longint'(sol[row])), 6'd0,
                                          1'b1, fault_flag});
      OP_CLEAR: begin
        foreach (col_start[i]) col_start[i] = 0;
        foreach (diag[i]) diag[i] = 0;
        n_entries = 0;
        prev_col  = 0;
      end
      default: ;
    endcase
  endfunction

  initial begin
    foreach (col_start[i]) col_start[i] = 0;
    foreach (diag[i]) begin
      diag[i] = 0; rhs_v[i] = 0; sol[i] = 0; grad[i] = 0;
    end
    n_entries = 0; prev_col = 0;
    lfsr = 32'd1; fault_flag = 1'b0;
    r_dim = 2; r_epochs = 64; r_prec = 0;
    r_lo = 0; r_hi = 32'sd65536; r_init = 0; r_seed = 32'd1;
    errors_o = 0; pending_o = 0; checked_o = 0;
  end

  always @(posedge clk_i) begin
    outcome_t want;
    logic [63:0] got_value;
    if (rst_ni) begin
      // results first: nothing can come out on the edge its request goes in
      if (m_axis_tvalid && m_axis_tready) begin
        got_value = m_axis_tdata[63:0];
        if (outcome_q.size() == 0) begin
          errors_o++;
          if (errors_o <= 10)
            $display("%0t: unexpected result kind=%0d value=%h", $time, m_axis_tuser,
                     got_value);
        end else begin
          want = outcome_q.pop_front();
          checked_o++;
          if (m_axis_tuser !== want.kind || got_value !== want.value ||
              m_axis_tdata[EPOCH_LSB +: 6] !== want.epoch ||
              m_axis_tdata[FAULT_BIT] !== want.fault || m_axis_tlast !== want.last) begin
            errors_o++;
            if (errors_o <= 10)
              $display("%0t: mismatch exp kind=%0d val=%h ep=%0d last=%0d fault=%0d / got kind=%0d val=%h ep=%0d last=%0d fault=%0d",
                       $time, want.kind, want.value, want.epoch, want.last, want.fault,
                       m_axis_tuser, got_value, m_axis_tdata[EPOCH_LSB +: 6],
                       m_axis_tlast, m_axis_tdata[FAULT_BIT]);
          end
        end
      end
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_e'(cfg_index_i))
          CFG_DIMENSION:  r_dim    = cfg_data_i[8:0];
          CFG_MAX_EPOCHS: r_epochs = cfg_data_i[6:0];
          CFG_PRECISION:  r_prec   = {1'b0, cfg_data_i[62:0]};
          CFG_LOWER:      r_lo     = cfg_data_i[31:0];
          CFG_UPPER:      r_hi     = cfg_data_i[31:0];
          CFG_INITIAL:    r_init   = cfg_data_i[31:0];
          CFG_SEED:       r_seed   = cfg_data_i[31:0];
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready)
        predict_request(s_axis_tuser, s_axis_tdata[7:0], s_axis_tdata[15:8],
                        s_axis_tdata[47:16]);
      pending_o = outcome_q.size();
    end
  end

endmodule

`default_nettype wire

[tb/tb_box_qp_random_coordinate_descent.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Testbench for the box QP randomized coordinate descent solver
// Drives directed and random load/solve/read requests and register settings,
// with sender gaps, receiver stalls and a long back-pressure hold; the
// checker module predicts and compares the result stream.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_box_qp_random_coordinate_descent;
  import bqprcd_pkg::*;

  localparam logic [2:0] OP_UNUSED_LO = 3'd5;  // codes 5..7 do nothing
  localparam logic [2:0] OP_UNUSED_HI = 3'd7;
  localparam int ONE = 1 << DEF_FRACTION_BITS;  // 1.0 in Q16.16
  localparam int SETTLE = 300;                   // load opening up to 256 columns
  localparam int TARGET_REQUESTS = 410;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic                  s_valid = 1'b0;
  logic                  s_axis_tready;
  logic [S_TDATA_W-1:0]  s_data = '0;   // row[7:0], column[15:8], value[47:16]
  logic [S_TUSER_W-1:0]  s_user = '0;   // op[2:0]
  logic                  m_axis_tvalid;
  logic                  m_ready = 1'b0;
  logic [M_TDATA_W-1:0]  m_axis_tdata;  // result_value[63:0], epoch[69:64], fault[70]
  logic                  m_axis_tuser;  // kind[0]
  logic                  m_axis_tlast;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  int errors, pending, checked;

  // stimulus bookkeeping: solution entries that hold defined data
  bit sol_set[256];
  int n_requests, n_solves, n_reads;
  int send_idle_pct, recv_stall_pct;
  bit hold_req;
  int hold_len;

  always #5 clk_i = ~clk_i;

  box_qp_random_coordinate_descent uut (
    .clk_i, .rst_ni,
    .s_axis_tvalid(s_valid), .s_axis_tready,
    .s_axis_tdata(s_data), .s_axis_tuser(s_user),
    .m_axis_tvalid, .m_axis_tready(m_ready),
    .m_axis_tdata, .m_axis_tuser, .m_axis_tlast,
    .cfg_valid_i(cfg_valid), .cfg_ready_o,
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data)
  );

  tb_box_qp_random_coordinate_descent_checker checker_i (
    .clk_i, .rst_ni,
    .s_axis_tvalid(s_valid), .s_axis_tready,
    .s_axis_tdata(s_data), .s_axis_tuser(s_user),
    .m_axis_tvalid, .m_axis_tready(m_ready),
    .m_axis_tdata, .m_axis_tuser, .m_axis_tlast,
    .cfg_valid_i(cfg_valid), .cfg_ready_o,
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data),
    .errors_o(errors), .pending_o(pending), .checked_o(checked)
  );

  // result side: random stalls, or a long hold when asked for
  initial begin
    hold_req = 1'b0;
    hold_len = 0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        m_ready <= 1'b0;
        repeat (hold_len) @(posedge clk_i);
      end else begin
        m_ready <= (recv_stall_pct == 0) || ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  initial begin
    #20ms;
    $display("Simulation FAILED");
    $finish;
  end

  // one request; tvalid stays high from one request to the next unless a gap falls
  task automatic put_request(int op, int row, int col, logic [31:0] val);
    if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      s_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    s_valid <= 1'b1;
    s_user  <= 3'(op);
    s_data  <= {val, 8'(col), 8'(row)};
    do @(posedge clk_i); while (!s_axis_tready);
    n_requests++;
    case (op)
      OP_SOLVE:    n_solves++;
      OP_READ:     n_reads++;
      default: ;
    endcase
  endtask

  task automatic drain();
    s_valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  // writes every register; only called with the block idle
  task automatic configure(int dim, int epochs, logic [63:0] prec, logic [31:0] lo,
                           logic [31:0] hi, logic [31:0] init, logic [31:0] seed);
    logic [63:0] vals[7];
    vals = '{64'(dim), 64'(epochs), prec, 64'(lo), 64'(hi), 64'(init), 64'(seed)};
    for (int i = 0; i < 7; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= cfg_e'(i);
      cfg_data  <= vals[i];
      do @(posedge clk_i); while (!cfg_ready_o);
    end
    cfg_valid <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic solve_and_mark(int dim);
    int d;
    d = (dim < 2) ? 2 : (dim > 256) ? 256 : dim;
    for (int i = 0; i < d; i++) sol_set[i] = 1'b1;
    put_request(OP_SOLVE, $urandom, $urandom, $urandom);
  endtask

  task automatic read_some(int count);
    int r;
    for (int i = 0; i < count; i++) begin
      do r = $urandom_range(255); while (!sol_set[r]);
      put_request(OP_READ, r, $urandom, $urandom);
    end
  endtask

  function automatic logic [31:0] pick_rhs();
    if ($urandom_range(9) == 0) return $urandom;
    return $urandom_range(0, 16 * ONE) - 8 * ONE;
  endfunction

  // one random problem: settings, matrix, rhs, solve, read-back
  task automatic random_problem(int idx);
    int dim, d, epochs, sel, k, r;
    logic [63:0] prec;
    logic [31:0] lo, hi, init, v;
    drain();
    send_idle_pct  = (idx % 4 == 1) ? 51 : (idx % 4 == 3) ? 17 : 0;
    recv_stall_pct = (idx % 4 == 2) ? 51 : (idx % 4 == 3) ? 17 : 0;
    d = $urandom_range(2, 6);
    dim = ($urandom_range(9) == 0) ? $urandom_range(0, 1) : d;  // 0 and 1 clamp to 2
    if (dim < 2) d = 2;
    sel = $urandom_range(9);
    epochs = (sel == 0) ? 0 : (sel == 1) ? 127 : $urandom_range(1, 12);
    sel = $urandom_range(4);
    prec = (sel < 3) ? 64'd0 : (sel == 3) ? 64'($urandom) : {$urandom, $urandom};
    k = $urandom_range(ONE, 8 * ONE);
    case ($urandom_range(2))
      0: begin lo = -k; hi = k; end
      1: begin hi = $urandom; lo = hi + $urandom_range(0, ONE); end  // no box unless hi + step wraps
      default: begin lo = $urandom; hi = $urandom; end
    endcase
    init = $urandom_range(1) ? $urandom : $urandom_range(0, 2 * k) - k;
    configure(dim, epochs, prec, lo, hi, init, $urandom_range(7) == 0 ? 0 : $urandom);
    if ($urandom_range(4) != 0) put_request(OP_CLEAR, $urandom, $urandom, $urandom);
    for (int i = 0; i < d; i++) put_request(OP_LOAD_RHS, i, $urandom, pick_rhs());
    for (int c = 0; c < d; c++) begin
      // off-diagonal entries, mostly inside the problem
      repeat ($urandom_range(0, 2)) begin
        r = ($urandom_range(7) == 0) ? $urandom_range(255) : $urandom_range(0, d - 1);
        v = ($urandom_range(9) == 0) ? $urandom : $urandom_range(0, ONE) - ONE / 2;
        put_request(OP_LOAD_ENTRY, r, c, v);
      end
      sel = $urandom_range(19);
      if (sel != 0) begin
        v = (sel == 1) ? 32'd0 : (sel == 2) ? $urandom : $urandom_range(ONE, 8 * ONE);
        put_request(OP_LOAD_ENTRY, c, c, v);
      end
      // stray traffic: entry for an earlier column, unused codes, loose rhs
      if (c > 0 && $urandom_range(5) == 0)
        put_request(OP_LOAD_ENTRY, $urandom, c - 1, $urandom);
      if ($urandom_range(7) == 0)
        put_request($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI), $urandom, $urandom, $urandom);
      if ($urandom_range(9) == 0)
        put_request(OP_LOAD_RHS, $urandom_range(255), $urandom, $urandom);
    end
    if ($urandom_range(11) == 0) put_request(OP_LOAD_ENTRY, $urandom, 255, $urandom);
    if (idx == 1) begin
      // long hold with many reports queued behind it
      hold_len = 3000;
      hold_req = 1'b1;
    end
    solve_and_mark(dim);
    read_some($urandom_range(1, idx == 1 ? 12 : 4));
  endtask

  initial begin
    int problems;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    n_requests = 0; n_solves = 0; n_reads = 0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: box [-2, 2], start outside the box, zero seed
    configure(3, 4, 64'd0, -2 * ONE, 2 * ONE, 32'h7FFF_FFFF, 32'd0);
    put_request(OP_LOAD_RHS, 0, 0, 32'h7FFF_FFFF);
    put_request(OP_LOAD_RHS, 1, 0, 32'h8000_0000);
    put_request(OP_LOAD_RHS, 2, 0, ONE);
    put_request(OP_LOAD_RHS, 255, 0, 32'h5A5A_A5A5);
    put_request(OP_LOAD_ENTRY, 0, 0, 4 * ONE);
    put_request(OP_LOAD_ENTRY, 1, 0, -ONE);
    put_request(OP_LOAD_ENTRY, 1, 1, 32'd0);
    put_request(OP_LOAD_ENTRY, 1, 1, 3 * ONE);        // later diagonal wins
    put_request(OP_LOAD_ENTRY, 0, 0, 5 * ONE);        // column goes back: dropped
    put_request(OP_LOAD_ENTRY, 2, 2, 32'h7FFF_FFFF);
    put_request(OP_LOAD_ENTRY, 255, 2, 32'h8000_0000);
    put_request(OP_LOAD_ENTRY, 7, 255, 32'hFFFF_FFFF);
    for (logic [2:0] op = OP_UNUSED_LO; op != 3'd0; op++)
      put_request(op, 255, 255, 32'hFFFF_FFFF);
    solve_and_mark(3);
    read_some(3);
    put_request(OP_CLEAR, 0, 0, 0);
    solve_and_mark(3);                                // all diagonals zero: fault
    put_request(OP_READ, 2, 0, 0);

    // largest problem, no box, one epoch
    drain();
    configure(511, 2, 64'd0, 0, 0, $urandom, 32'hFFFF_FFFF);
    put_request(OP_CLEAR, 0, 0, 0);
    for (int i = 0; i < 256; i++) put_request(OP_LOAD_RHS, i, 0, pick_rhs());
    for (int c = 0; c < 8; c++) put_request(OP_LOAD_ENTRY, c * 31, c * 31, 2 * ONE);
    solve_and_mark(511);
    read_some(2);

    // longest run of reports
    drain();
    configure(2, 100, 64'd0, 32'h8000_0000, 32'h7FFF_FFFF, 0, 32'hDEAD_BEEF);
    put_request(OP_CLEAR, 0, 0, 0);
    put_request(OP_LOAD_ENTRY, 0, 0, ONE / 2);
    put_request(OP_LOAD_ENTRY, 1, 0, 3 * ONE);
    put_request(OP_LOAD_ENTRY, 1, 1, ONE);
    put_request(OP_LOAD_ENTRY, 0, 1, -3 * ONE);
    solve_and_mark(2);

    // at least one random problem in each idling phase
    problems = 0;
    while (n_requests < TARGET_REQUESTS || problems < 4) begin
      random_problem(problems);
      problems++;
    end

    drain();
    $display("Sent %0d requests (%0d solves, %0d reads) over %0d random problems;",
             n_requests, n_solves, n_reads, problems);
    $display("checked %0d results under gaps, stalls and a long hold.", checked);
    if (errors == 0 && pending == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
